/* design/dcs_pkg.sv */
// Shared types and constants of the difference constraint solver.
package dcs_pkg;

  localparam int MaxNodes = 64;
  localparam int MaxEdges = 256;
  localparam int NodeW    = $clog2(MaxNodes);
  localparam int EdgeAw   = $clog2(MaxEdges);
  localparam int LinkW    = EdgeAw + 1;
  localparam int CntW     = NodeW + 1;
  localparam int WeightW  = 16;
  localparam int DistW    = 22;

  typedef enum logic [1:0] {
    OpAdd   = 2'd0,
    OpSolve = 2'd1,
    OpClear = 2'd2,
    OpNone  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StatusOk         = 2'd0,
    StatusInfeasible = 2'd1,
    StatusOverflow   = 2'd2
  } status_e;

  typedef enum logic [11:0] {
    StIdle    = 12'b0000_0000_0001,
    StAdd     = 12'b0000_0000_0010,
    StInit    = 12'b0000_0000_0100,
    StPop     = 12'b0000_0000_1000,
    StPopW    = 12'b0000_0001_0000,
    StVload   = 12'b0000_0010_0000,
    StEdge    = 12'b0000_0100_0000,
    StEdgeW   = 12'b0000_1000_0000,
    StNodeW   = 12'b0001_0000_0000,
    StEmitRd  = 12'b0010_0000_0000,
    StEmitOut = 12'b0100_0000_0000,
    StFail    = 12'b1000_0000_0000
  } state_e;

  typedef struct packed {
    logic [NodeW-1:0]          dest;
    logic signed [WeightW-1:0] weight;
    logic [LinkW-1:0]          next;
  } edge_t;

  typedef struct packed {
    logic signed [DistW-1:0] dval;
    logic [CntW-1:0]         hop;
    logic                    inq;
  } node_t;

endpackage

/* design/dcs_ram.sv */
// Generic one-write one-read RAM with registered read data.
module dcs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/difference_constraint_solver_core.sv */
// Top level of the difference constraint solver (queue-based Bellman-Ford).
//
// Channel | Dir | Signals                         | Moves
// s_axis  | in  | tvalid tready tdata tuser       | op item: add, solve, clear
// m_axis  | out | tvalid tready tdata tuser tlast | one distance or infeasible item
// cfg     | in  | cfg_valid cfg_ready cfg_data    | node_count register write
//
// Add reads the list head, then writes the edge and the new head; clear acts on accept.
// Solve: an init pass seeds the n active variables; each dequeued variable is then
// loaded and its outgoing edges relaxed one at a time, all bound by the single node memory
// port; then each item is read and emitted while the output is free.
// Reset clears control state and the list head valid bits; no sweep.
// Input is stalled while an item is in work; output backpressure holds emit.
module difference_constraint_solver_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // target_var[5:0], ref_var[11:6], bound[27:12]
  input  logic [1:0]  s_axis_tuser_i,   // op[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // node[5:0], distance[27:6]
  output logic [1:0]  m_axis_tuser_o,   // status[1:0]
  output logic        m_axis_tlast_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i
);
  import dcs_pkg::*;

  state_e state_q, state_d;

  logic [CntW-1:0]  nc_q;
  logic [LinkW-1:0] edge_total_q, edge_total_d;
  logic             ovf_q, ovf_d;
  logic [MaxNodes-1:0] head_vld_q, head_vld_d;
  logic             hvld_rd_q;

  logic [NodeW-1:0]          a_tgt_q, a_ref_q;
  logic signed [WeightW-1:0] a_w_q;

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [NodeW-1:0] rd_q, rd_d, wr_q, wr_d;
  logic [CntW-1:0]  fill_q, fill_d;
  logic [NodeW-1:0] v_q, v_d, d_q, d_d;
  logic signed [DistW-1:0]   dist_v_q, dist_v_d;
  logic [CntW-1:0]  hop_v_q, hop_v_d;
  logic [LinkW-1:0] link_q, link_d;
  logic signed [WeightW-1:0] w_q, w_d;

  logic        m_valid_q, m_valid_d;
  logic [NodeW-1:0] m_node_q, m_node_d;
  logic signed [DistW-1:0] m_dist_q, m_dist_d;
  status_e     m_status_q, m_status_d;
  logic        m_last_q, m_last_d;

  logic [CntW-1:0] n_act;
  logic            in_acc, out_free;
  op_e             in_op;

  // Memory ports
  logic              edge_we, head_we, node_we, fifo_we;
  logic [EdgeAw-1:0] edge_waddr, edge_raddr;
  edge_t             edge_wdata, edge_rdata;
  logic [NodeW-1:0]  head_waddr, head_raddr, node_waddr, node_raddr;
  logic [NodeW-1:0]  fifo_waddr, fifo_raddr, fifo_wdata, fifo_rdata;
  logic [LinkW-1:0]  head_wdata, head_rdata;
  node_t             node_wdata, node_rdata;

  logic signed [DistW:0] cand;
  logic [CntW-1:0]       cand_hop;

  dcs_ram #(.Width($bits(edge_t)), .Depth(MaxEdges)) u_edge_ram (
    .clk_i, .we_i(edge_we), .waddr_i(edge_waddr), .wdata_i(edge_wdata),
    .raddr_i(edge_raddr), .rdata_o(edge_rdata)
  );
  dcs_ram #(.Width(LinkW), .Depth(MaxNodes)) u_head_ram (
    .clk_i, .we_i(head_we), .waddr_i(head_waddr), .wdata_i(head_wdata),
    .raddr_i(head_raddr), .rdata_o(head_rdata)
  );
  dcs_ram #(.Width($bits(node_t)), .Depth(MaxNodes)) u_node_ram (
    .clk_i, .we_i(node_we), .waddr_i(node_waddr), .wdata_i(node_wdata),
    .raddr_i(node_raddr), .rdata_o(node_rdata)
  );
  dcs_ram #(.Width(NodeW), .Depth(MaxNodes)) u_fifo_ram (
    .clk_i, .we_i(fifo_we), .waddr_i(fifo_waddr), .wdata_i(fifo_wdata),
    .raddr_i(fifo_raddr), .rdata_o(fifo_rdata)
  );

  // Clamp node count into the active range
  always_comb begin
    if (nc_q == '0) begin
      n_act = CntW'(1);
    end else if (nc_q > CntW'(MaxNodes)) begin
      n_act = CntW'(MaxNodes);
    end else begin
      n_act = nc_q;
    end
  end

  assign s_axis_tready_o = (state_q == StIdle);
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign in_op    = op_e'(s_axis_tuser_i);
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign cfg_ready_o = 1'b1;

  assign cand     = $signed({dist_v_q[DistW-1], dist_v_q})
                  + $signed({{(DistW+1-WeightW){w_q[WeightW-1]}}, w_q});
  assign cand_hop = hop_v_q + CntW'(1);

  // Sequencer
  always_comb begin
    state_d      = state_q;
    edge_total_d = edge_total_q;
    ovf_d        = ovf_q;
    head_vld_d   = head_vld_q;
    cnt_d        = cnt_q;
    rd_d         = rd_q;
    wr_d         = wr_q;
    fill_d       = fill_q;
    v_d          = v_q;
    d_d          = d_q;
    dist_v_d     = dist_v_q;
    hop_v_d      = hop_v_q;
    link_d       = link_q;
    w_d          = w_q;
    m_valid_d    = m_axis_tready_i ? 1'b0 : m_valid_q;
    m_node_d     = m_node_q;
    m_dist_d     = m_dist_q;
    m_status_d   = m_status_q;
    m_last_d     = m_last_q;

    edge_we    = 1'b0;
    edge_waddr = edge_total_q[EdgeAw-1:0];
    edge_wdata = '{dest: a_tgt_q, weight: a_w_q,
                   next: hvld_rd_q ? head_rdata : '0};
    edge_raddr = EdgeAw'(link_q - LinkW'(1));
    head_we    = 1'b0;
    head_waddr = a_ref_q;
    head_wdata = edge_total_q + LinkW'(1);
    head_raddr = (state_q == StIdle) ? s_axis_tdata_i[11:6] : fifo_rdata;
    node_we    = 1'b0;
    node_waddr = cnt_q[NodeW-1:0];
    node_wdata = '{dval: '0, hop: CntW'(1), inq: 1'b1};
    node_raddr = cnt_q[NodeW-1:0];
    fifo_we    = 1'b0;
    fifo_waddr = cnt_q[NodeW-1:0];
    fifo_wdata = cnt_q[NodeW-1:0];
    fifo_raddr = rd_q;

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          case (in_op)
            OpAdd:   state_d = StAdd;
            OpSolve: begin
              cnt_d   = '0;
              state_d = StInit;
            end
            OpClear: begin
              edge_total_d = '0;
              ovf_d        = 1'b0;
              head_vld_d   = '0;
            end
            default: ;
          endcase
        end
      end
      StAdd: begin
        // Link the new edge in front of its origin's list
        if (edge_total_q >= LinkW'(MaxEdges)) begin
          ovf_d = 1'b1;
        end else begin
          edge_we             = 1'b1;
          head_we             = 1'b1;
          head_vld_d[a_ref_q] = 1'b1;
          edge_total_d        = edge_total_q + LinkW'(1);
        end
        state_d = StIdle;
      end
      StInit: begin
        // Seed every active variable and queue it
        node_we = 1'b1;
        fifo_we = 1'b1;
        cnt_d   = cnt_q + CntW'(1);
        if (cnt_q == n_act - CntW'(1)) begin
          rd_d    = '0;
          wr_d    = n_act[NodeW-1:0];
          fill_d  = n_act;
          state_d = StPop;
        end
      end
      StPop: begin
        if (fill_q == '0) begin
          cnt_d   = '0;
          state_d = StEmitRd;
        end else begin
          rd_d    = rd_q + NodeW'(1);
          fill_d  = fill_q - CntW'(1);
          state_d = StPopW;
        end
      end
      StPopW: begin
        node_raddr = fifo_rdata;
        v_d        = fifo_rdata;
        state_d    = ({1'b0, fifo_rdata} >= n_act) ? StPop : StVload;
      end
      StVload: begin
        // Take the variable off the queue, hold its distance and hop count
        dist_v_d   = node_rdata.dval;
        hop_v_d    = node_rdata.hop;
        node_we    = 1'b1;
        node_waddr = v_q;
        node_wdata = '{dval: node_rdata.dval, hop: node_rdata.hop, inq: 1'b0};
        link_d     = hvld_rd_q ? head_rdata : '0;
        state_d    = StEdge;
      end
      StEdge: begin
        state_d = (link_q == '0) ? StPop : StEdgeW;
      end
      StEdgeW: begin
        link_d     = edge_rdata.next;
        d_d        = edge_rdata.dest;
        w_d        = edge_rdata.weight;
        node_raddr = edge_rdata.dest;
        state_d    = ({1'b0, edge_rdata.dest} >= n_act) ? StEdge : StNodeW;
      end
      StNodeW: begin
        // Relax the edge; on improvement fail past n hops, else update and queue the destination if not queued
        state_d = StEdge;
        if ($signed({node_rdata.dval[DistW-1], node_rdata.dval}) > cand) begin
          if (cand_hop > n_act) begin
            state_d = StFail;
          end else begin
            node_we    = 1'b1;
            node_waddr = d_q;
            node_wdata = '{dval: cand[DistW-1:0], hop: cand_hop, inq: 1'b1};
            if (!node_rdata.inq && fill_q < CntW'(MaxNodes)) begin
              fifo_we    = 1'b1;
              fifo_waddr = wr_q;
              fifo_wdata = d_q;
              wr_d       = wr_q + NodeW'(1);
              fill_d     = fill_q + CntW'(1);
            end
            if (d_q == v_q) begin
              dist_v_d = cand[DistW-1:0];
              hop_v_d  = cand_hop;
            end
          end
        end
      end
      StEmitRd: begin
        state_d = StEmitOut;
      end
      StEmitOut: begin
        if (out_free) begin
          m_valid_d  = 1'b1;
          m_node_d   = cnt_q[NodeW-1:0];
          m_dist_d   = node_rdata.dval;
          m_status_d = ovf_q ? StatusOverflow : StatusOk;
          m_last_d   = (cnt_q == n_act - CntW'(1));
          cnt_d      = cnt_q + CntW'(1);
          state_d    = (cnt_q == n_act - CntW'(1)) ? StIdle : StEmitRd;
        end
      end
      StFail: begin
        if (out_free) begin
          m_valid_d  = 1'b1;
          m_node_d   = '0;
          m_dist_d   = '0;
          m_status_d = StatusInfeasible;
          m_last_d   = 1'b1;
          state_d    = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      nc_q         <= CntW'(MaxNodes);
      edge_total_q <= '0;
      ovf_q        <= 1'b0;
      head_vld_q   <= '0;
      m_valid_q    <= 1'b0;
      fill_q       <= '0;
      rd_q         <= '0;
      wr_q         <= '0;
      cnt_q        <= '0;
    end else begin
      state_q      <= state_d;
      edge_total_q <= edge_total_d;
      ovf_q        <= ovf_d;
      head_vld_q   <= head_vld_d;
      m_valid_q    <= m_valid_d;
      fill_q       <= fill_d;
      rd_q         <= rd_d;
      wr_q         <= wr_d;
      cnt_q        <= cnt_d;
      if (cfg_valid_i && cfg_ready_o) begin
        nc_q <= cfg_data_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    hvld_rd_q  <= head_vld_q[head_raddr];
    v_q        <= v_d;
    d_q        <= d_d;
    dist_v_q   <= dist_v_d;
    hop_v_q    <= hop_v_d;
    link_q     <= link_d;
    w_q        <= w_d;
    m_node_q   <= m_node_d;
    m_dist_q   <= m_dist_d;
    m_status_q <= m_status_d;
    m_last_q   <= m_last_d;
    if (in_acc) begin
      a_tgt_q <= s_axis_tdata_i[5:0];
      a_ref_q <= s_axis_tdata_i[11:6];
      a_w_q   <= s_axis_tdata_i[27:12];
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {4'b0, m_dist_q, m_node_q};
  assign m_axis_tuser_o  = m_status_q;
  assign m_axis_tlast_o  = m_last_q;

endmodule

/* design/dcs_checker.sv */
// Port-level checker of the difference constraint solver and its bind.
module dcs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [31:0] s_axis_tdata_i,
  input logic [1:0]  s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic [6:0]  cfg_data_i
);
  import dcs_pkg::*;

  // Hold a stalled result item
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled output item changed");

  // Infeasible item closes the run
  a_fail_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == StatusInfeasible |-> m_axis_tlast_o &&
    m_axis_tdata_o[27:0] == 28'd0)
    else $error("infeasible item malformed");

  // Distances never exceed zero
  a_dist_nonpos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[27] || m_axis_tdata_o[27:6] == 22'd0)
    else $error("positive distance");

  // No input taken while a solve is emitting and not done
  a_no_accept_midrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> !s_axis_tready_o)
    else $error("input accepted during a run");

endmodule

bind difference_constraint_solver_core dcs_checker u_dcs_checker (.*);

/* tb/tb_top.sv */
// Self-checking testbench of the difference constraint solver core.
`timescale 1ns / 100ps

module tb_top;
  import dcs_pkg::*;

  typedef struct {
    logic [5:0]         node;
    logic signed [21:0] dval;
    status_e            status;
    logic               last;
  } dist_item_t;

  typedef struct {
    op_e                op;
    logic [5:0]         tgt;
    logic [5:0]         src;
    logic signed [15:0] bound;
    bit                 typed;
    dist_item_t         exp_item;
  } stim_row_t;

  localparam int IdleLimit = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = '0;
  logic [1:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [6:0]  cfg_data_i = '0;

  difference_constraint_solver_core dut (.*);

  always #5 clk_i = ~clk_i;

  // Predictor state: constraint store and node count register
  logic [6:0]         node_reg;
  logic [5:0]         e_dest [MaxEdges];
  logic signed [15:0] e_wt   [MaxEdges];
  int                 e_next [MaxEdges];
  int                 head   [MaxNodes];
  int                 edge_cnt;
  bit                 ovf;

  dist_item_t expected_q[$];
  int  errors = 0;
  int  idle_cycles = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;

  function automatic void clear_edges();
    foreach (head[i]) head[i] = 0;
    edge_cnt = 0;
    ovf = 1'b0;
  endfunction

  // Queue-based Bellman-Ford over the stored constraints
  function automatic void solve_distances();
    int n, rd, wr, fill, v, link, e, dd;
    longint d [MaxNodes];
    int hop [MaxNodes];
    bit inq [MaxNodes];
    int fifo [MaxNodes];
    longint cand, sat;
    bit cycle;
    dist_item_t it;
    n = (node_reg == 0) ? 1 : ((node_reg > MaxNodes) ? MaxNodes : node_reg);
    rd = 0; wr = 0; fill = 0; cycle = 0;
    for (int i = 0; i < n; i++) begin
      d[i] = 0; hop[i] = 1; inq[i] = 1;
      fifo[wr] = i; wr = (wr + 1) % MaxNodes; fill++;
    end
    while (fill > 0 && !cycle) begin
      v = fifo[rd]; rd = (rd + 1) % MaxNodes; fill--;
      inq[v] = 0;
      link = head[v];
      while (link != 0 && !cycle) begin
        e = link - 1;
        dd = e_dest[e];
        link = e_next[e];
        if (dd < n) begin
          cand = d[v] + e_wt[e];
          if (d[dd] > cand) begin
            if (hop[v] + 1 > n) begin
              cycle = 1;
            end else begin
              hop[dd] = hop[v] + 1;
              d[dd] = cand;
              if (!inq[dd] && fill < MaxNodes) begin
                inq[dd] = 1;
                fifo[wr] = dd; wr = (wr + 1) % MaxNodes; fill++;
              end
            end
          end
        end
      end
    end
    if (cycle) begin
      it.node = 0; it.dval = 0; it.status = StatusInfeasible; it.last = 1;
      expected_q.push_back(it);
      return;
    end
    for (int i = 0; i < n; i++) begin
      sat = d[i];
      if (sat < -2097152) sat = -2097152;
      if (sat > 2097151) sat = 2097151;
      it.node = 6'(i);
      it.dval = sat[21:0];
      it.status = ovf ? StatusOverflow : StatusOk;
      it.last = (i == n - 1);
      expected_q.push_back(it);
    end
  endfunction

  function automatic void apply_item(op_e op, logic [5:0] tgt, logic [5:0] src,
                                     logic signed [15:0] bound);
    case (op)
      OpAdd: begin
        if (edge_cnt >= MaxEdges) begin
          ovf = 1'b1;
        end else begin
          e_dest[edge_cnt] = tgt;
          e_wt[edge_cnt] = bound;
          e_next[edge_cnt] = head[src];
          head[src] = edge_cnt + 1;
          edge_cnt++;
        end
      end
      OpClear: clear_edges();
      OpSolve: solve_distances();
      default: ;
    endcase
  endfunction

  // Send one item, idling the sender at random first
  task automatic send_item(op_e op, logic [5:0] tgt, logic [5:0] src,
                           logic signed [15:0] bound);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {4'b0, bound, src, tgt};
    s_axis_tuser_i <= op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    apply_item(op, tgt, src, bound);
  endtask

  // Write node_count once the block has drained
  task automatic write_node_count(logic [6:0] val);
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    node_reg = val;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic void set_idling(int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
      default: begin send_idle_pct = 36; recv_stall_pct = 36; end
    endcase
  endfunction

  // Random mix: mostly adds among the first span variables, some solves, clears and no-op items
  task automatic run_random(int count, int span, bit hold_first_solve);
    int r;
    bit held;
    logic [5:0] tgt, src;
    logic signed [15:0] bound;
    held = 0;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if ($urandom_range(9) == 0) begin
        tgt = 6'($urandom); src = 6'($urandom);
      end else begin
        tgt = 6'($urandom_range(span - 1)); src = 6'($urandom_range(span - 1));
      end
      case ($urandom_range(9))
        0: bound = 16'($urandom);
        1, 2: bound = 16'($signed($urandom_range(400)) - 200);
        default: bound = 16'($signed($urandom_range(60)) - 10);
      endcase
      if (r < 5) begin
        send_item(OpClear, tgt, src, bound);
      end else if (r < 8) begin
        send_item(OpNone, tgt, src, bound);
      end else if (r < 20) begin
        if (hold_first_solve && !held) begin
          // hold off until the block has delivered everything
          s_axis_tvalid_i <= 1'b0;
          @(posedge clk_i);
          while (expected_q.size() != 0) @(posedge clk_i);
          held = 1;
        end
        send_item(OpSolve, tgt, src, bound);
      end else begin
        send_item(OpAdd, tgt, src, bound);
      end
    end
  endtask

  // Receiver stalls at random
  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each delivered item with the oldest expectation
  always @(posedge clk_i) begin
    dist_item_t got, want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got.node = m_axis_tdata_o[5:0];
      got.dval = m_axis_tdata_o[27:6];
      got.status = status_e'(m_axis_tuser_o);
      got.last = m_axis_tlast_o;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected item node=%0d dist=%0d status=%0d last=%0b",
                 $time, got.node, got.dval, got.status, got.last);
      end else begin
        want = expected_q.pop_front();
        if (got.node !== want.node || got.dval !== want.dval ||
            got.status !== want.status || got.last !== want.last) begin
          errors++;
          $display("%0t: mismatch expected node=%0d dist=%0d status=%0d last=%0b",
                   $time, want.node, want.dval, want.status, want.last);
          $display("%0t:          actual   node=%0d dist=%0d status=%0d last=%0b",
                   $time, got.node, got.dval, got.status, got.last);
        end
      end
    end
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    stim_row_t table_rows[$];
    stim_row_t row;
    int first;
    node_reg = 7'd64;
    clear_edges();

    // Directed rows: empty solve, extremes, negative cycle, clear, unknown op
    table_rows = '{
      '{OpSolve, 6'd0,  6'd0,  16'sd0,     1, '{6'd0, 22'sd0, StatusOk, 1'b0}},
      '{OpAdd,   6'd1,  6'd0,  -16'sd5,    0, '{6'd0, 22'sd0, StatusOk, 1'b0}},
      '{OpAdd,   6'd63, 6'd1,  -16'sd32768, 0, '{6'd0, 22'sd0, StatusOk, 1'b0}},
      '{OpAdd,   6'd0,  6'd63, 16'sd32767, 0, '{6'd0, 22'sd0, StatusOk, 1'b0}},
      '{OpAdd,   6'd62, 6'd63, -16'sd32768, 0, '{6'd0, 22'sd0, StatusOk, 1'b0}},
      '{OpSolve, 6'd0,  6'd0,  16'sd0,     0, '{6'd0, 22'sd0, StatusOk, 1'b0}},
      '{OpNone,  6'd63, 6'd63, -16'sd1,    0, '{6'd0, 22'sd0, StatusOk, 1'b0}},
      '{OpAdd,   6'd0,  6'd1,  -16'sd1,    0, '{6'd0, 22'sd0, StatusOk, 1'b0}},
      '{OpSolve, 6'd0,  6'd0,  16'sd0,     1, '{6'd0, 22'sd0, StatusInfeasible, 1'b1}},
      '{OpClear, 6'd0,  6'd0,  16'sd0,     0, '{6'd0, 22'sd0, StatusOk, 1'b0}},
      '{OpAdd,   6'd5,  6'd5,  16'sd3,     0, '{6'd0, 22'sd0, StatusOk, 1'b0}},
      '{OpSolve, 6'd0,  6'd0,  16'sd0,     1, '{6'd0, 22'sd0, StatusOk, 1'b0}}
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_idling(0);
    foreach (table_rows[i]) begin
      row = table_rows[i];
      first = expected_q.size();
      send_item(row.op, row.tgt, row.src, row.bound);
      if (row.typed) expected_q[first] = row.exp_item;
    end

    // Above the node limit acts as the limit
    write_node_count(7'd127);
    set_idling(1);
    run_random(10, 64, 0);

    // Zero acts as one variable
    write_node_count(7'd0);
    set_idling(2);
    run_random(6, 3, 0);

    write_node_count(7'd1);
    set_idling(3);
    run_random(6, 2, 0);

    begin
      logic [6:0] nc;
      nc = 7'($urandom_range(16, 2));
      write_node_count(nc);
      set_idling(0);
      run_random(12, nc + 2, 1);
    end

    // Fill the store past capacity behind a negative cycle
    write_node_count(7'd8);
    set_idling(1);
    send_item(OpClear, 6'd0, 6'd0, 16'sd0);
    send_item(OpAdd, 6'd1, 6'd0, -16'sd1);
    send_item(OpAdd, 6'd0, 6'd1, -16'sd1);
    for (int k = 0; k < 255; k++) begin
      send_item(OpAdd, 6'($urandom_range(9)), 6'($urandom_range(9)),
                16'($urandom_range(50)));
    end
    send_item(OpSolve, 6'd0, 6'd0, 16'sd0);

    // Cycle out of range: overflow status on every item
    write_node_count(7'd1);
    set_idling(2);
    send_item(OpSolve, 6'd0, 6'd0, 16'sd0);

    write_node_count(7'd64);
    set_idling(3);
    send_item(OpClear, 6'd0, 6'd0, 16'sd0);
    run_random(8, 64, 0);

    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

/* files.f */
design/dcs_pkg.sv
design/dcs_ram.sv
design/difference_constraint_solver_core.sv
design/dcs_checker.sv
tb/tb_top.sv
